>>> rtl/pin_list_to_mask_parser_defines.svh
// ----------------------------------------------------------------------------
// pin list to mask parser: assertion macros
// ----------------------------------------------------------------------------
`ifndef PIN_LIST_TO_MASK_PARSER_DEFINES_SVH
`define PIN_LIST_TO_MASK_PARSER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define PL2M_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define PL2M_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/pl2m_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl2m_pkg
// Shared widths, character codes and the character class decode.
// ----------------------------------------------------------------------------
package pl2m_pkg;

  localparam int CHAR_W = 8;
  localparam int ACC_W  = 10;
  localparam int PROD_W = 14;
  localparam int OUT_W  = 16;

  localparam logic [ACC_W-1:0] ACC_MAX = 10'd1023;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // one-hot class of an incoming character
  typedef struct packed {
    logic is_term;
    logic is_blank;
    logic is_digit;
    logic is_sep;
    logic is_range;
    logic is_bad;
  } chr_class_t;

  function automatic chr_class_t classify(input logic [CHAR_W-1:0] ch);
    chr_class_t cls;
    cls          = '0;
    cls.is_term  = (ch == CH_NUL);
    cls.is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
    cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cls.is_sep   = (ch == CH_COMMA) || (ch == CH_SEMI);
    cls.is_range = (ch == CH_DASH) || (ch == CH_COLON);
    cls.is_bad   = !(cls.is_term || cls.is_blank || cls.is_digit ||
                     cls.is_sep || cls.is_range);
    return cls;
  endfunction

endpackage

>>> rtl/pl2m_range_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl2m_range_fill
// Turns the two ends of a pin range into a run of set bits, one compare pair
// per mask bit, and flags an end beyond the mask.
// ----------------------------------------------------------------------------
module pl2m_range_fill #(
  parameter int MASK_BITS = 16
) (
  input  logic [pl2m_pkg::ACC_W-1:0] end_a,
  input  logic [pl2m_pkg::ACC_W-1:0] end_b,
  output logic [MASK_BITS-1:0]       fill,
  output logic                       too_high
);

  logic [pl2m_pkg::ACC_W-1:0] lo;
  logic [pl2m_pkg::ACC_W-1:0] hi;

  // order the two ends
  always_comb begin
    if (end_b < end_a) begin
      lo = end_b;
      hi = end_a;
    end else begin
      lo = end_a;
      hi = end_b;
    end
  end

  assign too_high = (hi >= pl2m_pkg::ACC_W'(MASK_BITS));

  // each bit checks its own position against both ends
  always_comb begin
    for (int i = 0; i < MASK_BITS; i++) begin
      fill[i] = (lo <= pl2m_pkg::ACC_W'(i)) && (pl2m_pkg::ACC_W'(i) <= hi);
    end
  end

endmodule

>>> rtl/pl2m_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl2m_parser
// Parser state and its combinational next-state update for one character word.
// ----------------------------------------------------------------------------
module pl2m_parser #(
  parameter int MASK_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [pl2m_pkg::CHAR_W-1:0] ch,
  output logic                        is_term,
  output logic [MASK_BITS-1:0]        res_mask,
  output logic                        res_ok
);

  pl2m_pkg::chr_class_t cls;

  logic [pl2m_pkg::ACC_W-1:0] acc_r,   acc_nxt;
  logic [pl2m_pkg::ACC_W-1:0] low_r,   low_nxt;
  logic                       open_r,  open_nxt;
  logic [MASK_BITS-1:0]       mask_r,  mask_nxt;
  logic                       err_r,   err_nxt;
  logic                       start_r, start_nxt;

  logic [pl2m_pkg::ACC_W-1:0]  fill_lo;
  logic [MASK_BITS-1:0]        fill;
  logic                        fill_err;
  logic [MASK_BITS-1:0]        closed_mask;
  logic                        closed_err;
  logic [pl2m_pkg::PROD_W-1:0] prod;

  assign cls     = pl2m_pkg::classify(ch);
  assign is_term = cls.is_term;

  // closing the current number or range
  assign fill_lo = open_r ? low_r : acc_r;

  pl2m_range_fill #(
    .MASK_BITS (MASK_BITS)
  ) u_fill (
    .end_a    (fill_lo),
    .end_b    (acc_r),
    .fill     (fill),
    .too_high (fill_err)
  );

  assign closed_mask = mask_r | fill;
  assign closed_err  = err_r | fill_err;

  // decimal accumulate
  assign prod = pl2m_pkg::PROD_W'(acc_r) * pl2m_pkg::PROD_W'(10)
              + pl2m_pkg::PROD_W'(ch - pl2m_pkg::CH_ZERO);

  // next state and result for this character
  always_comb begin
    acc_nxt   = acc_r;
    low_nxt   = low_r;
    open_nxt  = open_r;
    mask_nxt  = mask_r;
    err_nxt   = err_r;
    start_nxt = 1'b0;
    res_mask  = start_r ? '0 : closed_mask;
    res_ok    = start_r ? 1'b1 : !closed_err;
    priority if (cls.is_term) begin
      acc_nxt   = '0;
      low_nxt   = '0;
      open_nxt  = 1'b0;
      mask_nxt  = '0;
      err_nxt   = 1'b0;
      start_nxt = 1'b1;
    end else if (cls.is_digit) begin
      acc_nxt = (prod > pl2m_pkg::PROD_W'(pl2m_pkg::ACC_MAX)) ?
                pl2m_pkg::ACC_MAX : prod[pl2m_pkg::ACC_W-1:0];
    end else if (cls.is_sep) begin
      mask_nxt = closed_mask;
      err_nxt  = closed_err;
      open_nxt = 1'b0;
      low_nxt  = '0;
      acc_nxt  = '0;
    end else if (cls.is_range) begin
      low_nxt  = acc_r;
      open_nxt = 1'b1;
      acc_nxt  = '0;
    end else if (cls.is_bad) begin
      err_nxt = 1'b1;
    end else begin
      // blank: nothing changes but the start flag
      acc_nxt = acc_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      low_r   <= '0;
      open_r  <= 1'b0;
      mask_r  <= '0;
      err_r   <= 1'b0;
      start_r <= 1'b1;
    end else if (step) begin
      acc_r   <= acc_nxt;
      low_r   <= low_nxt;
      open_r  <= open_nxt;
      mask_r  <= mask_nxt;
      err_r   <= err_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

>>> rtl/pin_list_to_mask_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pin_list_to_mask_parser
// Parses a pin list such as "1,4-7;9", one character word at a time, into a
// pin mask and an ok flag given out when the zero terminator arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_character carries one character
//   word per accepted cycle; a zero character ends the string. Only the
//   terminator yields a result word on out_valid / out_stall with
//   out_pin_mask and out_ok; every other character yields nothing.
//   Throughput is one character per cycle while in_stall is low: the parser
//   state update sits between the input register and the result register.
//   A terminator accepted into the input register is parsed and written to
//   the result register, which drives out_valid.
//   While the receiver stalls a held result, further non-terminator
//   characters are still accepted; a second terminator waits in the input
//   register and in_stall is raised until the result register frees.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the start of a string. After each terminator the parser
//   state returns to its reset values for the next string.
// ----------------------------------------------------------------------------
`include "pin_list_to_mask_parser_defines.svh"

module pin_list_to_mask_parser #(
  parameter int MASK_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pl2m_pkg::CHAR_W-1:0] in_character,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pl2m_pkg::OUT_W-1:0]  out_pin_mask,
  output logic                        out_ok
);

  logic                        in_valid_r;
  logic [pl2m_pkg::CHAR_W-1:0] in_char_r;
  logic                        out_valid_r;
  logic [pl2m_pkg::OUT_W-1:0]  out_mask_r;
  logic                        out_ok_r;

  logic                               is_term;
  logic [MASK_BITS-1:0]               res_mask;
  logic                               res_ok;
  logic [MASK_BITS+pl2m_pkg::OUT_W-1:0] res_ext;
  logic                               out_free;
  logic                               fire;

  // a word moves on unless it is a terminator facing a full result register
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && (!is_term || out_free);
  assign in_stall = in_valid_r && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_character;
    end
  end

  pl2m_parser #(
    .MASK_BITS (MASK_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (fire),
    .ch       (in_char_r),
    .is_term  (is_term),
    .res_mask (res_mask),
    .res_ok   (res_ok)
  );

  // low bits of the mask, zero padded when the mask is narrow
  assign res_ext = {{pl2m_pkg::OUT_W{1'b0}}, res_mask};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && is_term) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_term) begin
      out_mask_r <= res_ext[pl2m_pkg::OUT_W-1:0];
      out_ok_r   <= res_ok;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pin_mask = out_mask_r;
  assign out_ok       = out_ok_r;

  // checks
  `PL2M_ASSERT_NEXT(a_term_gives_word, fire && is_term, out_valid_r, "terminator lost")
  `PL2M_ASSERT_NEXT(a_no_extra_word, out_valid_r && !out_stall && !(fire && is_term),
    !out_valid_r, "result word repeated")
  `PL2M_ASSERT_SAME(a_stall_only_on_term, in_stall,
    in_valid_r && is_term && out_valid_r && out_stall, "input stalled without cause")

endmodule
